FILE: sv/stg_pkg.sv
// Package: constants, types and helpers shared by the sensor trend block.
`default_nettype none
package stg_pkg;
	localparam int LagShortDef  = 3;
	localparam int LagMediumDef = 6;
	localparam int LagLongDef   = 18;
	localparam int DivW         = 32;
	localparam logic [16:0] DaylightMinReset = 17'd1000;
	localparam logic [0:0]  RegDaylightMinLux = 1'b0;

	// One stored sample: readings and valid bits.
	typedef struct packed {
		logic        pv;
		logic        hv;
		logic        tv;
		logic        lv;
		logic [16:0] p;
		logic [13:0] h;
		logic signed [14:0] t;
		logic [16:0] l;
	} sample_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_DIV,
		ST_NEXT,
		ST_OUT
	} state_t;

	// Saturate a wide signed value to w bits, returned in 24 bits.
	function automatic logic signed [23:0] sat24(input logic signed [39:0] v, input int w);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		hi = (40'sd1 <<< (w - 1)) - 40'sd1;
		lo = -hi - 40'sd1;
		if (v > hi) return hi[23:0];
		if (v < lo) return lo[23:0];
		return v[23:0];
	endfunction
endpackage
`default_nettype wire

FILE: sv/stg_cell.sv
// One history cell: holds a sample and hands it to the next cell on a shift.
`default_nettype none
module stg_cell (
	input  wire logic                clk,
	input  wire logic                shift,
	input  wire stg_pkg::sample_t    din,
	output stg_pkg::sample_t         dout
);
	stg_pkg::sample_t data_q;

	// Advance the sample on a shift.
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= din;
		end
	end

	assign dout = data_q;
endmodule
`default_nettype wire

FILE: sv/stg_div.sv
// Restoring divider, one quotient bit a cycle, signed dividend, truncated.
`default_nettype none
module stg_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [39:0]      dividend,
	input  wire logic [stg_pkg::DivW-1:0] divisor,
	output logic                         done,
	output logic signed [39:0]           quotient
);
	logic [39:0] rem_q;
	logic [39:0] quo_q;
	logic [39:0] div_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [40:0] trial;

	assign trial = {rem_q[39:0], quo_q[39]} - {1'b0, div_q};

	// Step one bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd40;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Hold the working registers.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[39];
			quo_q <= dividend[39] ? 40'(-dividend) : dividend;
			rem_q <= '0;
			div_q <= 40'(divisor);
		end else if (busy_q) begin
			if (!trial[40]) begin
				rem_q <= trial[39:0];
				quo_q <= {quo_q[38:0], 1'b1};
			end else begin
				rem_q <= {rem_q[38:0], quo_q[39]};
				quo_q <= {quo_q[38:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule
`default_nettype wire

FILE: sv/sensor_trend_gradients.sv
// Top level: sample history chain, trend arithmetic and stream/APB ports.
// Each sample is shifted into the history, then its quotients run one after
// another through one shared bit-serial divider at one bit a cycle; at most
// eight quotients are due (when the sample count equals LAG_MEDIUM and a drop
// percentage is computed). The result sits in an output register, and a new
// sample is taken once the previous result has been accepted from that register.
`default_nettype none
module sensor_trend_gradients #(
	parameter int LAG_SHORT  = stg_pkg::LagShortDef,
	parameter int LAG_MEDIUM = stg_pkg::LagMediumDef,
	parameter int LAG_LONG   = stg_pkg::LagLongDef
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [0:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// pressure[16:0], humidity[30:17], temperature[45:31], light[62:46],
	// pressure_ok[63], humidity_ok[64], temperature_ok[65], light_ok[66]
	input  wire logic [71:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status[0], light_delta_short[18:1], light_drop_percent[32:19],
	// pressure_delta_medium[53:33], humidity_delta_medium[70:54],
	// temperature_delta_medium[88:71], light_delta_medium[109:89],
	// pressure_delta_long[129:110], humidity_delta_long[146:130],
	// temperature_delta_long[163:147], history_complete[164]
	output logic [167:0]      m_tdata
);
	localparam int LagSm = (LAG_SHORT > LAG_MEDIUM) ? LAG_SHORT : LAG_MEDIUM;
	localparam int Depth = ((LAG_LONG > LagSm) ? LAG_LONG : LagSm) + 1;
	localparam int CntW  = $clog2(Depth + 1);

	logic [16:0] daylight_q;
	stg_pkg::sample_t cur_q;
	stg_pkg::sample_t oldest_q;
	stg_pkg::sample_t chain [Depth];
	stg_pkg::sample_t cell_out [Depth];
	logic [CntW-1:0] count_q;
	logic shift;
	stg_pkg::state_t state_q, state_d;

	logic signed [23:0] res_q [9];
	logic status_q, hc_q;
	logic [3:0] job_q;
	logic div_start, div_done;
	logic signed [39:0] div_num;
	logic [stg_pkg::DivW-1:0] div_den;
	logic signed [39:0] div_quo;
	logic job_en;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			daylight_q <= stg_pkg::DaylightMinReset;
		end else if (psel && penable && pwrite && paddr == stg_pkg::RegDaylightMinLux) begin
			daylight_q <= pwdata[16:0];
		end
	end
	assign prdata = (paddr == stg_pkg::RegDaylightMinLux) ? {15'd0, daylight_q} : 32'd0;

	// History cell chain: cell 0 holds the current sample.
	genvar g;
	generate
		for (g = 0; g < Depth; g++) begin : g_cell
			if (g == 0) begin : g_first
				assign chain[g] = cur_q;
			end else begin : g_rest
				assign chain[g] = cell_out[g-1];
			end
			stg_cell u_cell (.clk(clk), .shift(shift),
				.din(chain[g]), .dout(cell_out[g]));
		end
	endgenerate

	assign s_tready = (state_q == stg_pkg::ST_IDLE) && !m_tvalid;
	assign shift = (state_q == stg_pkg::ST_SHIFT);

	// Capture the request and count samples.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (shift && count_q != CntW'(Depth)) begin
			count_q <= count_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cur_q <= '{pv: s_tdata[63], hv: s_tdata[64], tv: s_tdata[65], lv: s_tdata[66],
				p: s_tdata[16:0], h: s_tdata[30:17], t: s_tdata[45:31], l: s_tdata[62:46]};
			if (count_q == '0) begin
				oldest_q <= '{pv: s_tdata[63], hv: s_tdata[64], tv: s_tdata[65],
					lv: s_tdata[66], p: s_tdata[16:0], h: s_tdata[30:17],
					t: s_tdata[45:31], l: s_tdata[62:46]};
			end
		end
	end

	// After the shift, cell k holds the sample k ago.
	stg_pkg::sample_t c, ss, sm, sl, o;
	logic cur_ok, med_dir, long_dir, med_sc, long_sc, short_ok, drop_ok;
	logic signed [18:0] dp_m, dh_m, dt_m, dl_m, dp_l, dh_l, dt_l, dl_s;
	logic [17:0] drop;
	assign c  = cell_out[0];
	assign ss = cell_out[LAG_SHORT];
	assign sm = cell_out[LAG_MEDIUM];
	assign sl = cell_out[LAG_LONG];
	assign o  = oldest_q;
	assign cur_ok = c.pv && c.hv && c.tv && c.lv;
	assign short_ok = count_q > CntW'(LAG_SHORT) && ss.lv;
	assign dl_s = $signed({2'b0, c.l}) - $signed({2'b0, ss.l});
	assign drop = {1'b0, ss.l} - {1'b0, c.l};
	assign drop_ok = short_ok && ss.l >= daylight_q && ss.l != 17'd0 && ss.l > c.l;
	assign med_dir = count_q > CntW'(LAG_MEDIUM);
	assign long_dir = count_q > CntW'(LAG_LONG);
	assign med_sc = !med_dir && count_q > CntW'(1) && o.pv && o.hv && o.tv;
	assign long_sc = !long_dir && count_q >= CntW'(LAG_MEDIUM) && count_q > CntW'(1)
		&& o.pv && o.hv && o.tv;
	logic signed [18:0] op, oh, ot, ol;
	assign op = $signed({2'b0, c.p}) - $signed({2'b0, o.p});
	assign oh = $signed({5'b0, c.h}) - $signed({5'b0, o.h});
	assign ot = 19'($signed(c.t)) - 19'($signed(o.t));
	assign ol = $signed({2'b0, c.l}) - $signed({2'b0, o.l});

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			stg_pkg::ST_IDLE:  if (s_tvalid && s_tready) state_d = stg_pkg::ST_SHIFT;
			stg_pkg::ST_SHIFT: state_d = stg_pkg::ST_NEXT;
			stg_pkg::ST_NEXT:  state_d = (job_q == 4'd9) ? stg_pkg::ST_OUT :
				(job_en ? stg_pkg::ST_DIV : stg_pkg::ST_NEXT);
			stg_pkg::ST_DIV:   if (div_done) state_d = stg_pkg::ST_NEXT;
			stg_pkg::ST_OUT:   state_d = stg_pkg::ST_IDLE;
			default:           state_d = stg_pkg::ST_IDLE;
		endcase
	end

	// Select the quotient job: 0 drop, 1-4 medium, 5-7 long.
	always_comb begin
		job_en  = 1'b0;
		div_num = '0;
		div_den = stg_pkg::DivW'(count_q) - 1'b1;
		case (job_q)
			4'd0: begin
				job_en  = cur_ok && drop_ok;
				div_num = 40'(drop) * 40'sd10000;
				div_den = stg_pkg::DivW'(ss.l);
			end
			4'd1: begin job_en = cur_ok && med_sc; div_num = 40'(op) * 40'(LAG_MEDIUM); end
			4'd2: begin job_en = cur_ok && med_sc; div_num = 40'(oh) * 40'(LAG_MEDIUM); end
			4'd3: begin job_en = cur_ok && med_sc; div_num = 40'(ot) * 40'(LAG_MEDIUM); end
			4'd4: begin
				job_en  = cur_ok && med_sc && o.lv;
				div_num = 40'(ol) * 40'(LAG_MEDIUM);
			end
			4'd5: begin job_en = cur_ok && long_sc; div_num = 40'(op) * 40'(LAG_LONG); end
			4'd6: begin job_en = cur_ok && long_sc; div_num = 40'(oh) * 40'(LAG_LONG); end
			4'd7: begin job_en = cur_ok && long_sc; div_num = 40'(ot) * 40'(LAG_LONG); end
			default: job_en = 1'b0;
		endcase
	end
	assign div_start = (state_q == stg_pkg::ST_NEXT) && job_en && job_q != 4'd9;

	stg_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quotient(div_quo));

	logic direct_ok_m, direct_ok_l;
	assign direct_ok_m = med_dir && sm.pv && sm.hv && sm.tv && sm.lv;
	assign direct_ok_l = long_dir && sl.pv && sl.hv && sl.tv;
	assign dp_m = $signed({2'b0, c.p}) - $signed({2'b0, sm.p});
	assign dh_m = $signed({5'b0, c.h}) - $signed({5'b0, sm.h});
	assign dt_m = 19'($signed(c.t)) - 19'($signed(sm.t));
	assign dl_m = $signed({2'b0, c.l}) - $signed({2'b0, sm.l});
	assign dp_l = $signed({2'b0, c.p}) - $signed({2'b0, sl.p});
	assign dh_l = $signed({5'b0, c.h}) - $signed({5'b0, sl.h});
	assign dt_l = 19'($signed(c.t)) - 19'($signed(sl.t));

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= stg_pkg::ST_IDLE;
			job_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == stg_pkg::ST_SHIFT) job_q <= '0;
			else if (state_q == stg_pkg::ST_NEXT && !job_en && job_q != 4'd9)
				job_q <= job_q + 4'd1;
			else if (state_q == stg_pkg::ST_DIV && div_done) job_q <= job_q + 4'd1;
			if (state_q == stg_pkg::ST_OUT) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == stg_pkg::ST_SHIFT) begin
			for (int k = 0; k < 9; k++) res_q[k] <= '0;
			status_q <= 1'b0;
			hc_q <= 1'b0;
		end else if (state_q == stg_pkg::ST_NEXT && job_q == 4'd8) begin
			status_q <= !cur_ok;
			if (cur_ok) begin
				if (short_ok) res_q[0] <= stg_pkg::sat24(40'(dl_s), 18);
				if (direct_ok_m) begin
					res_q[2] <= stg_pkg::sat24(40'(dp_m), 21);
					res_q[3] <= stg_pkg::sat24(40'(dh_m), 17);
					res_q[4] <= stg_pkg::sat24(40'(dt_m), 18);
					res_q[5] <= stg_pkg::sat24(40'(dl_m), 21);
				end
				if (direct_ok_l) begin
					res_q[6] <= stg_pkg::sat24(40'(dp_l), 20);
					res_q[7] <= stg_pkg::sat24(40'(dh_l), 17);
					res_q[8] <= stg_pkg::sat24(40'(dt_l), 17);
					hc_q <= 1'b1;
				end
			end
		end else if (state_q == stg_pkg::ST_DIV && div_done) begin
			case (job_q)
				4'd0: res_q[1] <= div_quo[23:0];
				4'd1: res_q[2] <= stg_pkg::sat24(div_quo, 21);
				4'd2: res_q[3] <= stg_pkg::sat24(div_quo, 17);
				4'd3: res_q[4] <= stg_pkg::sat24(div_quo, 18);
				4'd4: res_q[5] <= stg_pkg::sat24(div_quo, 21);
				4'd5: res_q[6] <= stg_pkg::sat24(div_quo, 20);
				4'd6: res_q[7] <= stg_pkg::sat24(div_quo, 17);
				4'd7: res_q[8] <= stg_pkg::sat24(div_quo, 17);
				default: ;
			endcase
		end
	end

	assign m_tdata = {3'd0, hc_q, res_q[8][16:0], res_q[7][16:0], res_q[6][19:0],
		res_q[5][20:0], res_q[4][17:0], res_q[3][16:0], res_q[2][20:0],
		res_q[1][13:0], res_q[0][17:0], status_q};
endmodule
`default_nettype wire

FILE: sv/stg_checker.sv
// Port-level checker for the sensor trend block, bound to the top level.
`default_nettype none
module stg_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [167:0] m_tdata
);
	// An invalid sample gives all-zero results.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[167:1] == '0) else $error("status with data");
	// No new request while a result waits.
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("took request with result pending");
	// An accepted request gives no result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
	// Result held while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
endmodule

bind sensor_trend_gradients stg_checker u_stg_checker (.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata));
`default_nettype wire

FILE: tb/sensor_trend_gradients_chk.sv
// Checker: watches the sample and result streams, predicts each result and compares it.
module sensor_trend_gradients_chk (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [0:0]   paddr,
	input  wire logic [31:0]  pwdata,
	input  wire logic         pready,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [71:0]  s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [167:0] m_tdata,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Depth = stg_pkg::LagLongDef + 1;
	localparam int FieldLo [11] = '{0, 1, 19, 33, 54, 71, 89, 110, 130, 147, 164};
	localparam int FieldW  [11] = '{1, 18, 14, 21, 17, 18, 21, 20, 17, 17, 1};

	stg_pkg::sample_t ring [Depth];
	stg_pkg::sample_t first_seen;
	int          seen_count;
	int          wr_idx;
	logic [16:0] daylight_min;
	logic [167:0] trend_queue [$];

	// Clamp to a w-bit two's-complement range.
	function automatic longint clamp(input longint v, input int w);
		longint hi;
		hi = (longint'(1) <<< (w - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic bit pht_valid(input stg_pkg::sample_t s);
		return s.pv && s.hv && s.tv;
	endfunction

	// Store one sample and return the packed trend result it produces.
	function automatic logic [167:0] trend_of(input stg_pkg::sample_t c);
		longint r [11];
		longint cp, ch, ct, cl, v;
		stg_pkg::sample_t s;
		int cur, n, iv;
		logic [167:0] res;
		cp = c.p; ch = c.h; ct = longint'($signed(c.t)); cl = c.l;
		res = '0;
		for (int i = 0; i < 11; i++) r[i] = 0;
		if (seen_count == 0) first_seen = c;
		cur = wr_idx;
		ring[cur] = c;
		wr_idx = (wr_idx + 1) % Depth;
		if (seen_count < Depth) seen_count++;
		n = seen_count;
		iv = n - 1;
		if (!(c.pv && c.hv && c.tv && c.lv)) begin
			r[0] = 1;
		end else begin
			if (n > stg_pkg::LagShortDef) begin
				s = ring[(cur + Depth - stg_pkg::LagShortDef) % Depth];
				if (s.lv) begin
					r[1] = cl - longint'(s.l);
					if (s.l >= daylight_min && s.l > 0 && longint'(s.l) > cl)
						r[2] = ((longint'(s.l) - cl) * 10000) / longint'(s.l);
				end
			end
			if (n > stg_pkg::LagMediumDef) begin
				s = ring[(cur + Depth - stg_pkg::LagMediumDef) % Depth];
				if (pht_valid(s) && s.lv) begin
					r[3] = cp - longint'(s.p);
					r[4] = ch - longint'(s.h);
					r[5] = ct - longint'($signed(s.t));
					r[6] = cl - longint'(s.l);
				end
			end else if (n > 1 && pht_valid(first_seen)) begin
				r[3] = ((cp - longint'(first_seen.p)) * stg_pkg::LagMediumDef) / iv;
				r[4] = ((ch - longint'(first_seen.h)) * stg_pkg::LagMediumDef) / iv;
				r[5] = ((ct - longint'($signed(first_seen.t))) * stg_pkg::LagMediumDef) / iv;
				if (first_seen.lv)
					r[6] = ((cl - longint'(first_seen.l)) * stg_pkg::LagMediumDef) / iv;
			end
			if (n > stg_pkg::LagLongDef) begin
				s = ring[(cur + Depth - stg_pkg::LagLongDef) % Depth];
				if (pht_valid(s)) begin
					r[7] = cp - longint'(s.p);
					r[8] = ch - longint'(s.h);
					r[9] = ct - longint'($signed(s.t));
					r[10] = 1;
				end
			end else if (n >= stg_pkg::LagMediumDef && n > 1 && pht_valid(first_seen)) begin
				r[7] = ((cp - longint'(first_seen.p)) * stg_pkg::LagLongDef) / iv;
				r[8] = ((ch - longint'(first_seen.h)) * stg_pkg::LagLongDef) / iv;
				r[9] = ((ct - longint'($signed(first_seen.t))) * stg_pkg::LagLongDef) / iv;
			end
		end
		// Pack fields; the drop percent is masked, the deltas saturate.
		for (int i = 0; i < 11; i++) begin
			v = (i == 0 || i == 2 || i == 10) ? r[i] : clamp(r[i], FieldW[i]);
			for (int b = 0; b < FieldW[i]; b++) res[FieldLo[i] + b] = v[b];
		end
		return res;
	endfunction

	// Track the register, predict on each request, compare on each result.
	always @(posedge clk or negedge arst_n) begin
		logic [167:0] want;
		logic [71:0]  d;
		stg_pkg::sample_t c;
		if (!arst_n) begin
			seen_count = 0;
			wr_idx = 0;
			daylight_min = stg_pkg::DaylightMinReset;
			errors = 0;
			trend_queue.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == stg_pkg::RegDaylightMinLux)
				daylight_min = pwdata[16:0];
			if (s_tvalid && s_tready) begin
				d = s_tdata;
				c.p = d[16:0]; c.h = d[30:17]; c.t = d[45:31]; c.l = d[62:46];
				c.pv = d[63]; c.hv = d[64]; c.tv = d[65]; c.lv = d[66];
				trend_queue.push_back(trend_of(c));
			end
			if (m_tvalid && m_tready) begin
				if (trend_queue.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_tdata);
					errors++;
				end else begin
					want = trend_queue.pop_front();
					for (int i = 0; i < 11; i++)
						for (int b = 0; b < FieldW[i]; b++)
							if (want[FieldLo[i] + b] !== m_tdata[FieldLo[i] + b]) begin
								$display("%0t: field %0d expected %h actual %h", $time, i,
									want >> FieldLo[i], m_tdata >> FieldLo[i]);
								errors++;
								break;
							end
				end
			end
			pending = trend_queue.size();
		end
	end
endmodule

FILE: tb/sensor_trend_gradients_tb.sv
// Testbench top: clock, reset, sample stimulus, register writes and verdict.
module sensor_trend_gradients_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk, arst_n;
	logic         psel, penable, pwrite;
	logic [0:0]   paddr;
	logic [31:0]  pwdata, prdata;
	logic         pready;
	logic         s_tvalid, s_tready, m_tvalid, m_tready;
	logic [71:0]  s_tdata;
	logic [167:0] m_tdata;
	int           errors, pending;
	int           send_idle, recv_idle;
	int           quiet;
	logic [16:0]  walk_p, walk_l;
	logic [13:0]  walk_h;
	logic signed [14:0] walk_t;

	sensor_trend_gradients dut (.*);
	sensor_trend_gradients_chk chk (.*);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result side at the phase's rate.
	always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

	// End the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("** sensor_trend_gradients: FAILED **");
			$finish;
		end
	end

	task automatic push_sample(input logic [16:0] p, input logic [13:0] h,
			input logic signed [14:0] t, input logic [16:0] l, input logic [3:0] ok);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_tdata <= {5'b0, ok[3], ok[2], ok[1], ok[0], l, t, h, p};
		s_tvalid <= 1'b1;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	// Hold requests until every result is back, then write the register.
	task automatic set_daylight(input logic [16:0] v);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= stg_pkg::RegDaylightMinLux; pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Random sample: mostly a drifting walk, sometimes a jump, rare bad readings.
	task automatic random_sample();
		logic [3:0] ok;
		for (int i = 0; i < 4; i++) ok[i] = ($urandom_range(99) < 93);
		if ($urandom_range(99) < 25) begin
			walk_p = 17'($urandom_range(110000));
			walk_h = 14'($urandom_range(10000));
			walk_t = 15'(int'($urandom_range(12500)) - 4000);
			walk_l = ($urandom_range(3) == 0) ? 17'($urandom_range(2000)) :
				17'($urandom_range(131071));
		end else begin
			walk_p = 17'((int'(walk_p) + int'($urandom_range(399))) % 110001);
			walk_h = 14'((int'(walk_h) + $urandom_range(200)) % 10001);
			walk_t = (walk_t > 8000) ? walk_t - 15'sd900 : walk_t + 15'($urandom_range(200));
			walk_l = walk_l - 17'($urandom_range(walk_l / 4 + 1));
		end
		push_sample(walk_p, walk_h, walk_t, walk_l, ok);
	endtask

	initial begin
		arst_n = 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		s_tvalid <= 1'b0; s_tdata <= '0; m_tready <= 1'b0;
		send_idle = 0; recv_idle = 0; quiet = 0;
		walk_p = 100000; walk_h = 5000; walk_t = 2000; walk_l = 50000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: invalid first sample, scaled history, extremes, dim light.
		push_sample(17'd110000, 14'd10000, 15'sd8500, 17'd131071, 4'b1110);
		push_sample(17'd0, 14'd0, -15'sd4000, 17'd0, 4'b1111);
		push_sample(17'd110000, 14'd10000, 15'sd8500, 17'd131071, 4'b1111);
		push_sample(17'd0, 14'd0, -15'sd4000, 17'd0, 4'b1111);
		push_sample(17'd55000, 14'd5000, 15'sd0, 17'd999, 4'b0111);
		push_sample(17'd110000, 14'd10000, 15'sd8500, 17'd1000, 4'b1111);
		push_sample(17'd0, 14'd0, -15'sd4000, 17'd131071, 4'b1011);
		push_sample(17'd110000, 14'd10000, 15'sd8500, 17'd0, 4'b1111);
		push_sample(17'd1, 14'd1, 15'sd1, 17'd500, 4'b1101);
		push_sample(17'd0, 14'd0, -15'sd4000, 17'd131071, 4'b1111);
		for (int i = 0; i < 14; i++)
			push_sample(17'($urandom_range(110000)), 14'($urandom_range(10000)),
				15'sd8500 - 15'(i * 800), 17'd131071 >> i, 4'b1111);
		set_daylight(17'd0);
		for (int i = 0; i < 30; i++) random_sample();
		set_daylight(17'd131071);
		for (int i = 0; i < 30; i++) random_sample();

		// Random phases at each idling mix.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 54; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 54; end
				default: begin send_idle = 38; recv_idle = 38; end
			endcase
			set_daylight((ph == 3) ? stg_pkg::DaylightMinReset : 17'($urandom_range(131071)));
			for (int i = 0; i < 405; i++) random_sample();
		end
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0) $display("** sensor_trend_gradients: PASSED **");
		else $display("** sensor_trend_gradients: FAILED **");
		$finish;
	end
endmodule
